// ----- rtl/assert_macros.svh -----
// shared assertion macros, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic CFG_IDX_HALF    = 1'b0;
    localparam logic CFG_IDX_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [7:0]  TIMEOUT_RESET     = 8'd250;
    localparam logic [7:0]  TIMEOUT_SAT       = 8'hFF;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_WAIT  = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;
    localparam logic [2:0] CMD_ACK   = 3'd6;
    localparam logic [2:0] CMD_NACK  = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] byte_in;
        logic       ack_after_read;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_output_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } res_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout_limit;
    } cfg_t;

endpackage

// ----- rtl/i2cm_stream_if.sv -----
`timescale 1ns / 1ps

interface i2cm_req_if;
    import i2cm_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/i2cm_seq.sv -----
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  i2cm_pkg::req_t item,
    input  i2cm_pkg::cfg_t cfg,
    output i2cm_pkg::res_t result
);
    import i2cm_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_TO_A, PH_TO_B,
        PH_AK_A, PH_AK_B, PH_WR_D, PH_WR_H, PH_WR_L, PH_WA_A, PH_WA_B,
        PH_WA_P, PH_RD_L, PH_RD_H
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  timeout_reg, timeout_next;
    logic        pending_reg, pending_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        oe_reg, oe_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        missing_reg, missing_next;
    logic        done_next;

    logic [15:0] hp;
    logic [15:0] delay_inc;
    logic        expired;
    logic [3:0]  bit_inc;
    logic [7:0]  read_shift;
    logic        poll_now;
    logic        to_fire;

    // zero half period behaves as one tick
    assign hp         = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
    assign delay_inc  = delay_reg + 16'd1;
    assign expired    = (delay_inc >= hp);
    assign bit_inc    = bit_count_reg + 4'd1;
    assign read_shift = {shift_reg[6:0], item.sda_in};
    assign poll_now   = (phase_reg == PH_WA_P) || ((phase_reg == PH_WA_B) && expired);
    assign to_fire    = (timeout_reg > cfg.ack_timeout_limit) || (timeout_reg == TIMEOUT_SAT);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        delay_next     = delay_reg;
        timeout_next   = timeout_reg;
        pending_next   = pending_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        oe_next        = oe_reg;
        last_read_next = last_read_reg;
        missing_next   = missing_reg;
        done_next      = 1'b0;

        if (phase_reg == PH_IDLE) begin
            unique case (item.command)
                CMD_START:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    oe_next    = 1'b1;
                    phase_next = PH_ST_A;
                    delay_next = '0;
                end
                CMD_STOP:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    oe_next    = 1'b1;
                    phase_next = PH_SP_A;
                    delay_next = '0;
                end
                CMD_WRITE:
                begin
                    bit_count_next = '0;
                    scl_next       = 1'b0;
                    oe_next        = 1'b1;
                    sda_next       = item.byte_in[7];
                    shift_next     = {item.byte_in[6:0], 1'b0};
                    phase_next     = PH_WR_D;
                    delay_next     = '0;
                end
                CMD_WAIT:
                begin
                    timeout_next = '0;
                    sda_next     = 1'b1;
                    oe_next      = 1'b0;
                    phase_next   = PH_WA_A;
                    delay_next   = '0;
                end
                CMD_READ:
                begin
                    pending_next   = item.ack_after_read;
                    shift_next     = '0;
                    bit_count_next = '0;
                    scl_next       = 1'b0;
                    sda_next       = 1'b1;
                    oe_next        = 1'b0;
                    phase_next     = PH_RD_L;
                    delay_next     = '0;
                end
                CMD_ACK, CMD_NACK:
                begin
                    pending_next = (item.command == CMD_ACK);
                    scl_next     = 1'b0;
                    sda_next     = (item.command != CMD_ACK);
                    oe_next      = 1'b1;
                    phase_next   = PH_AK_A;
                    delay_next   = '0;
                end
                default: ;
            endcase
        end else if (poll_now) begin
            // ack polling, scl held high until sda low or timeout
            phase_next = PH_WA_P;
            delay_next = '0;
            if (!item.sda_in) begin
                scl_next     = 1'b0;
                missing_next = 1'b0;
                phase_next   = PH_IDLE;
                done_next    = 1'b1;
            end else if (to_fire) begin
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                oe_next    = 1'b1;
                phase_next = PH_TO_A;
            end else begin
                timeout_next = timeout_reg + 8'd1;
            end
        end else begin
            delay_next = delay_inc;
            if (expired) begin
                delay_next = '0;
                unique case (phase_reg)
                    PH_ST_A:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST_B;
                    end
                    PH_SP_A, PH_TO_A:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = (phase_reg == PH_SP_A) ? PH_SP_B : PH_TO_B;
                    end
                    PH_ST_B, PH_AK_B:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_TO_B:
                    begin
                        scl_next     = 1'b0;
                        oe_next      = 1'b1;
                        missing_next = 1'b1;
                        phase_next   = PH_IDLE;
                        done_next    = 1'b1;
                    end
                    PH_AK_A:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_AK_B;
                    end
                    PH_WR_D:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_WR_H;
                    end
                    PH_WR_H:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_WR_L;
                    end
                    PH_WR_L:
                    begin
                        bit_count_next = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end else begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = PH_WR_D;
                        end
                    end
                    PH_WA_A:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_WA_B;
                    end
                    PH_RD_L:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_RD_H;
                    end
                    PH_RD_H:
                    begin
                        shift_next     = read_shift;
                        bit_count_next = bit_inc;
                        scl_next       = 1'b0;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            // byte complete, go straight into the ack bit
                            last_read_next = read_shift;
                            sda_next       = !pending_reg;
                            oe_next        = 1'b1;
                            phase_next     = PH_AK_A;
                        end else begin
                            phase_next = PH_RD_L;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            timeout_reg   <= '0;
            pending_reg   <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            oe_reg        <= 1'b1;
            last_read_reg <= '0;
            missing_reg   <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            delay_reg     <= delay_next;
            timeout_reg   <= timeout_next;
            pending_reg   <= pending_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            oe_reg        <= oe_next;
            last_read_reg <= last_read_next;
            missing_reg   <= missing_next;
        end
    end

    always_comb
    begin
        result.scl               = scl_next;
        result.sda_out           = sda_next;
        result.sda_output_enable = oe_next;
        result.busy_res          = (phase_next != PH_IDLE);
        result.done_res          = done_next;
        result.read_data         = last_read_next;
        result.ack_missing       = missing_next;
    end

    `ASSERT_CLK(a_hold_without_step, !step |=> $stable(phase_reg) && $stable(delay_reg), "sequencer state moved without a tick")
    `ASSERT_NEVER(a_delay_bound, (phase_reg != PH_IDLE) && (delay_reg >= hp), "delay count passed the half period")
    `ASSERT_NEVER(a_bit_bound, bit_count_reg > BITS_PER_BYTE, "bit count past one byte")
    `ASSERT_CLK(a_done_ends_busy, step && done_next |=> phase_reg == PH_IDLE, "done without returning to idle")

endmodule

// ----- rtl/i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps

// I2C master bit engine: drives scl, sda and the sda output enable one tick at a time.
// req channel: one request per timing tick, carrying the sampled sda level and, while
//   the engine is idle, a command (start, stop, write, wait ack, read, ack, nack).
//   Commands that arrive while busy are ignored; send command none then.
// res channel: one result per request with the line levels after that tick, busy,
//   a one-tick done pulse, the last byte read and the ack-missing flag.
// cfg port: cfg_we/cfg_index/cfg_data write half_period_ticks (index 0) or
//   ack_timeout_limit (index 1); write only while the engine is idle.
// Path: an accepted request waits in the input register, and its result is then
//   registered in the output register, where it can be taken.
// Throughput: one request per cycle while res.ready is high; the sequencer updates all
//   of its state at each step, so consecutive requests flow without gaps.
// Stalls: when res.ready is low the output register holds its result and the input
//   register holds the next request; req.ready drops only when both are full.
// Reset: lines idle high and driven, engine idle, half period 5, timeout limit 250.
module i2c_master_bit_engine (
    input  logic       clk,
    input  logic       rst_n,
    i2cm_req_if.sink   req,
    i2cm_res_if.source res,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cm_pkg::*;

    logic        req_valid_reg;
    req_t        req_data_reg;
    logic        res_valid_reg;
    res_t        res_data_reg;
    cfg_t        cfg_reg;
    logic        step;
    res_t        step_result;

    assign step      = req_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !req_valid_reg || step;
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.ack_timeout_limit <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_HALF:    cfg_reg.half_period_ticks <= cfg_data[15:0];
                CFG_IDX_TIMEOUT: cfg_reg.ack_timeout_limit <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register takes a new request whenever it drains or is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else if (req.ready) begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid) begin
            req_data_reg <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (step) begin
            res_valid_reg <= 1'b1;
        end else if (res.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            res_data_reg <= step_result;
        end
    end

    i2cm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (req_data_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

endmodule

// ----- test/i2c_master_bit_engine_tb.sv -----
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam int unsigned ITEM_BUDGET = 1550;

    typedef enum logic [4:0] {
        P_IDLE,
        P_START_SETUP,
        P_START_HOLD,
        P_STOP_SETUP,
        P_STOP_HOLD,
        P_TMO_SETUP,
        P_TMO_HOLD,
        P_ACK_LOW,
        P_ACK_HIGH,
        P_WR_DATA,
        P_WR_HIGH,
        P_WR_LOW,
        P_WAIT_LOW,
        P_WAIT_HIGH,
        P_WAIT_POLL,
        P_RD_LOW,
        P_RD_HIGH
    } seq_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2cm_req_if req_ch ();
    i2cm_res_if res_ch ();

    i2c_master_bit_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .res       (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // engine model state
    seq_phase_t  ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] dly;
    logic [7:0]  tmo;
    logic        ack_pick;
    logic        ln_scl;
    logic        ln_sda;
    logic        ln_oe;
    logic [7:0]  rd_last;
    logic        missing;
    logic        done_flag;
    logic [15:0] half_ticks;
    logic [7:0]  ack_limit;

    req_t pending_ticks[$];
    res_t line_state_q[$];
    res_t got_line;
    res_t want_line;

    int unsigned n_queued;
    int unsigned n_taken;
    int unsigned n_cmds;
    int unsigned n_fail;
    int unsigned n_acks;
    int unsigned n_timeouts;
    int unsigned n_reads;
    int unsigned n_settings;
    int unsigned src_gap;
    int unsigned snk_stall;
    bit          no_idle;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void hold_lines(logic c, logic d, logic e);
        ln_scl = c;
        ln_sda = d;
        ln_oe  = e;
    endfunction

    function automatic void go(seq_phase_t p);
        ph  = p;
        dly = '0;
    endfunction

    function automatic void complete();
        go(P_IDLE);
        done_flag = 1'b1;
    endfunction

    function automatic void drive_ack();
        hold_lines(1'b0, !ack_pick, 1'b1);
        go(P_ACK_LOW);
    endfunction

    function automatic void shift_out_bit();
        ln_sda = shreg[7];
        shreg  = {shreg[6:0], 1'b0};
        go(P_WR_DATA);
    endfunction

    function automatic void sample_ack(logic s);
        if (!s)
        begin
            ln_scl  = 1'b0;
            missing = 1'b0;
            n_acks++;
            complete();
        end
        else if (tmo > ack_limit || tmo == TIMEOUT_SAT)
        begin
            hold_lines(1'b0, 1'b0, 1'b1);
            go(P_TMO_SETUP);
        end
        else
            tmo = tmo + 8'd1;
    endfunction

    // line state after one tick of the engine
    function automatic res_t next_line_state(req_t r);
        res_t        o;
        logic [15:0] hp_eff;
        hp_eff    = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
        done_flag = 1'b0;
        if (ph == P_IDLE)
        begin
            case (r.command)
                CMD_START:
                begin
                    hold_lines(1'b1, 1'b1, 1'b1);
                    go(P_START_SETUP);
                end
                CMD_STOP:
                begin
                    hold_lines(1'b0, 1'b0, 1'b1);
                    go(P_STOP_SETUP);
                end
                CMD_WRITE:
                begin
                    shreg   = r.byte_in;
                    bit_cnt = '0;
                    hold_lines(1'b0, ln_sda, 1'b1);
                    shift_out_bit();
                end
                CMD_WAIT:
                begin
                    tmo = '0;
                    hold_lines(ln_scl, 1'b1, 1'b0);
                    go(P_WAIT_LOW);
                end
                CMD_READ:
                begin
                    ack_pick = r.ack_after_read;
                    shreg    = '0;
                    bit_cnt  = '0;
                    hold_lines(1'b0, 1'b1, 1'b0);
                    go(P_RD_LOW);
                end
                CMD_ACK:
                begin
                    ack_pick = 1'b1;
                    drive_ack();
                end
                CMD_NACK:
                begin
                    ack_pick = 1'b0;
                    drive_ack();
                end
                default:
                begin
                end
            endcase
        end
        else if (ph == P_WAIT_POLL)
            sample_ack(r.sda_in);
        else
        begin
            dly = dly + 16'd1;
            if (dly >= hp_eff)
            begin
                case (ph)
                    P_START_SETUP:
                    begin
                        ln_sda = 1'b0;
                        go(P_START_HOLD);
                    end
                    P_START_HOLD:
                    begin
                        ln_scl = 1'b0;
                        complete();
                    end
                    P_STOP_SETUP:
                    begin
                        ln_scl = 1'b1;
                        ln_sda = 1'b1;
                        go(P_STOP_HOLD);
                    end
                    P_TMO_SETUP:
                    begin
                        ln_scl = 1'b1;
                        ln_sda = 1'b1;
                        go(P_TMO_HOLD);
                    end
                    P_TMO_HOLD:
                    begin
                        ln_scl  = 1'b0;
                        ln_oe   = 1'b1;
                        missing = 1'b1;
                        n_timeouts++;
                        complete();
                    end
                    P_ACK_LOW:
                    begin
                        ln_scl = 1'b1;
                        go(P_ACK_HIGH);
                    end
                    P_ACK_HIGH:
                    begin
                        ln_scl = 1'b0;
                        complete();
                    end
                    P_WR_DATA:
                    begin
                        ln_scl = 1'b1;
                        go(P_WR_HIGH);
                    end
                    P_WR_HIGH:
                    begin
                        ln_scl = 1'b0;
                        go(P_WR_LOW);
                    end
                    P_WR_LOW:
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE)
                            complete();
                        else
                            shift_out_bit();
                    end
                    P_WAIT_LOW:
                    begin
                        ln_scl = 1'b1;
                        go(P_WAIT_HIGH);
                    end
                    P_WAIT_HIGH:
                    begin
                        go(P_WAIT_POLL);
                        sample_ack(r.sda_in);
                    end
                    P_RD_LOW:
                    begin
                        ln_scl = 1'b1;
                        go(P_RD_HIGH);
                    end
                    P_RD_HIGH:
                    begin
                        // bit sampled at the end of the scl high time
                        shreg   = {shreg[6:0], r.sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE)
                        begin
                            rd_last = shreg;
                            n_reads++;
                            drive_ack();
                        end
                        else
                        begin
                            ln_scl = 1'b0;
                            go(P_RD_LOW);
                        end
                    end
                    default:
                        complete();
                endcase
            end
        end
        o.scl               = ln_scl;
        o.sda_out           = ln_sda;
        o.sda_output_enable = ln_oe;
        o.busy_res          = (ph != P_IDLE);
        o.done_res          = done_flag;
        o.read_data         = rd_last;
        o.ack_missing       = missing;
        return o;
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            n_fail++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            src_gap      <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                line_state_q.push_back(next_line_state(req_ch.data));
                n_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap      <= src_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    req_ch.data  <= pending_ticks.pop_front();
                    req_ch.valid <= 1'b1;
                    src_gap      <= pick_gap();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_stall    <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got_line = res_ch.data;
                if (line_state_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    n_fail++;
                end
                else
                begin
                    want_line = line_state_q.pop_front();
                    check_field("scl", 8'(want_line.scl), 8'(got_line.scl));
                    check_field("sda_out", 8'(want_line.sda_out), 8'(got_line.sda_out));
                    check_field("sda_output_enable", 8'(want_line.sda_output_enable),
                                8'(got_line.sda_output_enable));
                    check_field("busy_res", 8'(want_line.busy_res), 8'(got_line.busy_res));
                    check_field("done_res", 8'(want_line.done_res), 8'(got_line.done_res));
                    check_field("read_data", want_line.read_data, got_line.read_data);
                    check_field("ack_missing", 8'(want_line.ack_missing),
                                8'(got_line.ack_missing));
                end
            end
            if (snk_stall != 0)
            begin
                snk_stall    <= snk_stall - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                snk_stall    <= pick_gap();
            end
        end
    end

    task automatic push_item(logic [2:0] c, logic [7:0] b, logic a, logic s);
        req_t it;
        it.command        = c;
        it.byte_in        = b;
        it.ack_after_read = a;
        it.sda_in         = s;
        pending_ticks.push_back(it);
        n_queued++;
    endtask

    // one command, then ticks until the engine is idle again; low_pm is the
    // chance in 1000 that the slave pulls sda low on a tick
    task automatic issue(logic [2:0] c, logic [7:0] b, logic a, int unsigned low_pm);
        logic [2:0] fc;
        push_item(c, b, a, 1'($urandom_range(0, 1)));
        n_cmds++;
        while (n_taken != n_queued || ph != P_IDLE)
        begin
            if (ph != P_IDLE && pending_ticks.size() < 2)
            begin
                // a command now and then while busy, which must be ignored
                fc = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
                push_item(fc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 999) < low_pm) ? 1'b0 : 1'b1);
            end
            @(negedge clk);
        end
    endtask

    task automatic slave_ack();
        int unsigned r;
        int unsigned pm;
        r = $urandom_range(0, 99);
        if (r < 8)
            pm = 0;
        else if (r < 40)
            pm = 1000;
        else if (r < 65)
            pm = 500;
        else if (r < 85)
            pm = 125;
        else
            pm = 30;
        issue(CMD_WAIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pm);
    endtask

    task automatic random_transaction();
        int unsigned n;
        if ($urandom_range(0, 4) == 0)
        begin
            issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 500);
            return;
        end
        issue(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 500);
        issue(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 500);
        slave_ack();
        n = $urandom_range(0, 3);
        for (int unsigned k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                issue(CMD_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 500);
                slave_ack();
            end
            else
                issue(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 500);
        end
        if ($urandom_range(0, 9) != 0)
            issue(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 500);
    endtask

    // hold the sender until every result is back and the engine is idle
    task automatic settle();
        do
        begin
            if (ph != P_IDLE && pending_ticks.size() == 0)
                push_item(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            @(negedge clk);
        end
        while (pending_ticks.size() != 0 || n_taken != n_queued || ph != P_IDLE
               || line_state_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] hp_v, logic [7:0] lim_v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_HALF;
        cfg_data  <= hp_v;
        @(posedge clk);
        cfg_index <= CFG_IDX_TIMEOUT;
        cfg_data  <= {8'h00, lim_v};
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        half_ticks = hp_v;
        ack_limit  = lim_v;
        n_settings++;
    endtask

    initial
    begin
        int unsigned r;
        logic [15:0] hp_v;
        logic [7:0]  lim_v;

        cfg_we       = 1'b0;
        cfg_index    = CFG_IDX_HALF;
        cfg_data     = '0;
        rst_n        = 1'b0;

        ph         = P_IDLE;
        bit_cnt    = '0;
        shreg      = '0;
        dly        = '0;
        tmo        = '0;
        ack_pick   = 1'b0;
        ln_scl     = 1'b1;
        ln_sda     = 1'b1;
        ln_oe      = 1'b1;
        rd_last    = '0;
        missing    = 1'b0;
        done_flag  = 1'b0;
        half_ticks = HALF_PERIOD_RESET;
        ack_limit  = TIMEOUT_RESET;
        n_settings = 1;
        no_idle    = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings
        issue(CMD_NONE, 8'h00, 1'b0, 500);
        issue(CMD_START, 8'hFF, 1'b1, 500);
        issue(CMD_WRITE, 8'h00, 1'b0, 500);
        issue(CMD_WAIT, 8'h00, 1'b0, 1000);
        issue(CMD_WAIT, 8'h00, 1'b0, 0);
        issue(CMD_STOP, 8'h00, 1'b0, 500);

        // short half period and small limit for the rest of the directed part
        settle();
        set_config(16'd1, 8'd3);
        issue(CMD_WRITE, 8'hFF, 1'b1, 500);
        // stop arrives while the write is still running
        push_item(CMD_WRITE, 8'hA5, 1'b0, 1'b1);
        push_item(CMD_STOP, 8'h5A, 1'b1, 1'b0);
        issue(CMD_NONE, 8'h00, 1'b0, 500);
        issue(CMD_WAIT, 8'h00, 1'b0, 0);
        issue(CMD_READ, 8'h00, 1'b1, 1000);
        issue(CMD_READ, 8'h00, 1'b0, 0);
        issue(CMD_READ, 8'h00, 1'b1, 500);
        issue(CMD_ACK, 8'h00, 1'b0, 500);
        issue(CMD_NACK, 8'hFF, 1'b1, 500);
        issue(CMD_WAIT, 8'h00, 1'b0, 125);
        issue(CMD_STOP, 8'h00, 1'b0, 500);
        issue(CMD_WAIT, 8'h00, 1'b0, 30);
        issue(CMD_WRITE, 8'h80, 1'b0, 500);
        issue(CMD_WRITE, 8'h01, 1'b0, 500);
        issue(CMD_STOP, 8'h00, 1'b0, 500);

        // zero half period behaves as one, timeout on the second high sample
        settle();
        set_config(16'd0, 8'd0);
        issue(CMD_WAIT, 8'h00, 1'b0, 0);
        repeat (2) random_transaction();

        // largest limit: count saturates and fires on the 256th high sample
        settle();
        set_config(16'd1, 8'd255);
        issue(CMD_WAIT, 8'h00, 1'b0, 0);
        repeat (2) random_transaction();

        // longer half period, one stop only, without idling
        settle();
        no_idle = 1'b1;
        set_config(16'd40, 8'($urandom_range(0, 255)));
        issue(CMD_STOP, 8'h00, 1'b0, 500);

        while (n_taken < ITEM_BUDGET)
        begin
            settle();
            r = $urandom_range(0, 9);
            if (r < 6)
                hp_v = 16'($urandom_range(1, 2));
            else if (r < 9)
                hp_v = 16'($urandom_range(1, 4));
            else
                hp_v = 16'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r < 4)
                lim_v = 8'($urandom_range(0, 40));
            else if (r < 8)
                lim_v = 8'($urandom_range(0, 255));
            else
                lim_v = (r == 8) ? 8'd0 : 8'd255;
            no_idle = ($urandom_range(0, 3) == 0);
            set_config(hp_v, lim_v);
            repeat ($urandom_range(1, 3))
                if (n_taken < ITEM_BUDGET)
                    random_transaction();
        end

        settle();
        repeat (8) @(negedge clk);
        $display("%0d commands in %0d ticks over %0d register settings",
                 n_cmds, n_taken, n_settings);
        $display("%0d acks seen, %0d ack timeouts, %0d bytes read",
                 n_acks, n_timeouts, n_reads);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_stream_if.sv
rtl/i2cm_seq.sv
rtl/i2c_master_bit_engine.sv
test/i2c_master_bit_engine_tb.sv
